// ===== sv/linear_probe_hash_table_assert.svh =====
// assertion macros for the hash table block
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// a condition that holds at every clock edge out of reset
`define LPHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// a condition that implies another in the following cycle
`define LPHT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define LPHT_ASSERT(label, prop, msg)

`define LPHT_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== sv/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

   localparam int LOG2_SLOTS = 10;
   localparam int SLOTS      = 1 << LOG2_SLOTS;
   localparam int IDX_W      = LOG2_SLOTS;
   localparam int CNT_W      = LOG2_SLOTS + 1;

   // an insert is refused once count + 1 reaches 60% of the slots, rounded up
   localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'((6 * SLOTS + 9) / 10);

   localparam logic [63:0] MIX_C1 = 64'h3C79AC492BA7B653;
   localparam logic [63:0] MIX_C2 = 64'h1C69B3F74AC4AE35;
   localparam int          MIX_S1 = 27;
   localparam int          MIX_S2 = 33;

   typedef enum logic [1:0] {
      OP_GET   = 2'd0,
      OP_PUT   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_ZERO_KEY  = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] lookup_key;
      logic [63:0] store_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] found_value;
      logic        was_inserted;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [63:0] key;
      logic [63:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } ram_cmd_type;

   // partial products of the two 64 x 64 multiplies, low half only
   typedef enum logic [2:0] {
      HS_MUL1_LL = 3'd0,
      HS_MUL1_LH = 3'd1,
      HS_MUL1_HL = 3'd2,
      HS_MUL2_LL = 3'd3,
      HS_MUL2_LH = 3'd4,
      HS_MUL2_HL = 3'd5
   } hash_step_type;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'd0,
      S_IDLE   = 3'd1,
      S_HASH   = 3'd2,
      S_PROBE  = 3'd3,
      S_FINISH = 3'd4
   } state_type;

endpackage

`default_nettype wire

// ===== sv/lpht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/lpht_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_hash
   import lpht_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [63:0]      key,
   output      logic             done,
   output      logic [IDX_W-1:0] home_idx
);

   logic             busy_ff, busy_in;
   hash_step_type    step_ff, step_in;
   logic [63:0]      x_ff, x_in;
   logic [63:0]      acc_ff, acc_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [31:0] mul_a;
   logic [31:0] mul_c;
   logic [63:0] prod;
   logic [31:0] hi_sum;
   logic [63:0] sum;
   logic [63:0] mixed;

   // one 32 x 32 multiplier, shared by all six partial products
   always_comb begin
      mul_a = x_ff[31:0];
      mul_c = 32'd0;
      case (step_ff)
         HS_MUL1_LL: mul_c = MIX_C1[31:0];
         HS_MUL1_LH: mul_c = MIX_C1[63:32];
         HS_MUL1_HL: begin
            mul_a = x_ff[63:32];
            mul_c = MIX_C1[31:0];
         end
         HS_MUL2_LL: mul_c = MIX_C2[31:0];
         HS_MUL2_LH: mul_c = MIX_C2[63:32];
         HS_MUL2_HL: begin
            mul_a = x_ff[63:32];
            mul_c = MIX_C2[31:0];
         end
         default: mul_c = 32'd0;
      endcase
   end

   assign prod   = 64'(mul_a) * 64'(mul_c);
   assign hi_sum = acc_ff[63:32] + prod[31:0];
   assign sum    = {hi_sum, acc_ff[31:0]};
   assign mixed  = sum ^ (sum >> MIX_S1);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      if (start) begin
         x_in    = key ^ (key >> MIX_S1);
         step_in = HS_MUL1_LL;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = hash_step_type'(step_ff + 3'd1);
         case (step_ff)
            HS_MUL1_LL, HS_MUL2_LL: acc_in = prod;
            HS_MUL1_LH, HS_MUL2_LH: acc_in = sum;
            HS_MUL1_HL:             x_in   = sum ^ (sum >> MIX_S2);
            HS_MUL2_HL: begin
               idx_in  = mixed[IDX_W-1:0];
               done_in = 1'b1;
               busy_in = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= HS_MUL1_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
   end

   assign done     = done_ff;
   assign home_idx = idx_ff;

endmodule

`default_nettype wire

// ===== sv/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_hash_table_assert.svh"

module lpht_ctrl
   import lpht_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_type          req_data,
   input  wire logic             out_free,
   output      logic             rsp_load,
   output      rsp_type          rsp_next,
   output      logic             hash_start,
   output      logic [63:0]      hash_key,
   input  wire logic             hash_done,
   input  wire logic [IDX_W-1:0] hash_idx,
   output      ram_cmd_type      ram_cmd,
   input  wire entry_type        ram_rdata
);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             sweep_rsp_ff, sweep_rsp_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             key_zero;
   logic             is_access;
   logic             hit;
   logic             probe_end;
   logic             at_limit;
   logic [CNT_W-1:0] count_inc;

   assign accept    = req_valid && req_ready;
   assign key_zero  = (req_data.lookup_key == 64'd0);
   assign is_access = (req_ff.opcode == OP_GET) || (req_ff.opcode == OP_PUT);
   assign hit       = ram_rdata.used && (ram_rdata.key == req_ff.lookup_key);
   assign probe_end = !ram_rdata.used || hit;
   assign count_inc = count_ff + 1'b1;
   assign at_limit  = (count_inc >= LOAD_LIMIT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (&sweep_ff) begin
               state_in = sweep_rsp_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (req_data.opcode == OP_NOP || key_zero) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (probe_end && out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      req_in       = req_ff;
      idx_in       = idx_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      count_in     = count_ff;
      hash_start   = 1'b0;
      hash_key     = req_data.lookup_key;
      rsp_load     = 1'b0;
      rsp_next     = '{status: ST_OK, found_value: 64'd0, was_inserted: 1'b0};
      ram_cmd      = '{rd_en: 1'b0, rd_addr: idx_ff, wr_en: 1'b0, wr_addr: idx_ff,
                       wr_data: '{used: 1'b1, key: req_ff.lookup_key,
                                  value: req_ff.store_value}};
      case (state_ff)
         S_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = sweep_ff;
            ram_cmd.wr_data = '0;
            sweep_in        = sweep_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.opcode == OP_CLEAR) begin
                  count_in     = '0;
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
               end else if (req_data.opcode != OP_NOP && !key_zero) begin
                  hash_start = 1'b1;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = hash_idx;
               idx_in          = hash_idx;
            end
         end
         S_PROBE: begin
            if (!probe_end) begin
               // occupied by another key: step on, wrapping at the end
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = idx_ff + 1'b1;
               idx_in          = idx_ff + 1'b1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               if (req_ff.opcode == OP_GET) begin
                  if (hit) begin
                     rsp_next.found_value = ram_rdata.value;
                  end else begin
                     rsp_next.status = ST_NOT_FOUND;
                  end
               end else if (hit) begin
                  ram_cmd.wr_en        = 1'b1;
                  rsp_next.found_value = req_ff.store_value;
               end else if (at_limit) begin
                  rsp_next.status = ST_FULL;
               end else begin
                  ram_cmd.wr_en         = 1'b1;
                  count_in              = count_inc;
                  rsp_next.found_value  = req_ff.store_value;
                  rsp_next.was_inserted = 1'b1;
               end
            end
         end
         S_FINISH: begin
            sweep_rsp_in = 1'b0;
            if (out_free) begin
               rsp_load = 1'b1;
               if (is_access) begin
                  rsp_next.status = ST_ZERO_KEY;
               end
            end
         end
         default: rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         count_ff     <= count_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
   end

   `LPHT_ASSERT(a_count_below_limit, count_ff < LOAD_LIMIT, "entry count reached load limit")
   `LPHT_ASSERT(a_no_read_write_overlap, !(ram_cmd.rd_en && ram_cmd.wr_en), "slot read and write together")
   `LPHT_ASSERT(a_hash_done_waited, !hash_done || state_ff == S_HASH, "hash finished while not waiting")
   `LPHT_ASSERT(a_load_when_free, !rsp_load || out_free, "response loaded over a pending one")
   `LPHT_ASSERT_NEXT(a_clear_empties, state_ff == S_CLEAR, count_ff == '0, "count not zero during clear")

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_table.sv =====
// linear_probe_hash_table: 64-bit key to 64-bit value store, open addressing
// req channel: opcode get, put, clear or nop with key and value, valid/ready
// rsp channel: status, found value and inserted flag, one per request
// home slot comes from a 64-bit mixer hash worked out on one shared 32 x 32
// multiplier in six steps; probing then reads one slot per cycle from a
// single slot memory with a registered read
// get/put: ready again in the same cycle that the result is registered, so
// one request is in flight at a time
// clear: one memory write per slot, then its response
// zero key and unused opcode: answered without touching memory
// reset: a clearing pass over all slots runs first, req_ready low
// the response register frees the engine: a new request is taken while a
// result waits; a further result holds in the engine until rsp_ready
// a put that would reach 60% load is refused with a full status
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   // engine to response register
   logic    out_free;
   logic    rsp_load;
   rsp_type rsp_next;

   // hash unit
   logic             hash_start;
   logic [63:0]      hash_key;
   logic             hash_done;
   logic [IDX_W-1:0] hash_idx;

   // slot memory
   ram_cmd_type ram_cmd;
   entry_type   ram_rdata;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   lpht_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key      (hash_key),
      .done     (hash_done),
      .home_idx (hash_idx)
   );

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rdata),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data)
   );

   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp_next   (rsp_next),
      .hash_start (hash_start),
      .hash_key   (hash_key),
      .hash_done  (hash_done),
      .hash_idx   (hash_idx),
      .ram_cmd    (ram_cmd),
      .ram_rdata  (ram_rdata)
   );

   // response register: load wins over drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
